// ----- design/jsu_pkg.sv -----
// Shared types and constants of the JSON string unescaper.
// Depends on nothing; every other file of the block imports it.
package jsu_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int REC_BYTES       = 6;

	localparam logic [1:0] STATUS_DECODING = 2'd0;
	localparam logic [1:0] STATUS_DONE     = 2'd1;
	localparam logic [1:0] STATUS_ERROR    = 2'd2;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_U     = 8'h75;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_STR,
		MODE_ESC,
		MODE_HEX,
		MODE_PEND,
		MODE_PEND_ESC,
		MODE_PEND_HEX
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       start_flag;
		logic       text_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        has_byte;
		logic [1:0]  status;
		logic [15:0] consumed_count;
		logic        last;
	} out_item_t;

	// Everything one text byte causes: decoded bytes, then an optional end result.
	typedef struct packed {
		logic [REC_BYTES-1:0][7:0] bytes;
		logic [2:0]                nbytes;
		logic                      has_tail;
		logic [1:0]                tail_status;
		logic [15:0]               count;
	} rec_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

// ----- design/jsu_front.sv -----
// Front end: takes text bytes, tracks escape state, builds at most one record per byte.
// Depends on jsu_pkg.
module jsu_front #(
	parameter int OFFSET_BITS = jsu_pkg::OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  jsu_pkg::in_item_t item,
	output logic              push,
	output jsu_pkg::rec_t     rec
);
	import jsu_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFF_LIMIT =
		(OFFSET_BITS >= 16) ? OFFSET_BITS'(16'hFFFF) : {OFFSET_BITS{1'b1}};

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} enc_t;

	function automatic enc_t utf8(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp <= 21'h7F) begin
			e.b[0] = cp[7:0];
			e.n = 3'd1;
		end else if (cp <= 21'h7FF) begin
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
			e.n = 3'd2;
		end else if (cp <= 21'hFFFF) begin
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
			e.n = 3'd3;
		end else begin
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
			e.n = 3'd4;
		end
		return e;
	endfunction

	// {valid, digit}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// {valid, byte} for the single-character escapes
	function automatic logic [8:0] esc_simple(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			CH_QUOTE: r = {1'b1, CH_QUOTE};
			CH_BSL:   r = {1'b1, CH_BSL};
			CH_SLASH: r = {1'b1, CH_SLASH};
			8'h62:    r = {1'b1, 8'h08};
			8'h66:    r = {1'b1, 8'h0C};
			8'h6E:    r = {1'b1, 8'h0A};
			8'h72:    r = {1'b1, 8'h0D};
			8'h74:    r = {1'b1, 8'h09};
			default:  r = '0;
		endcase
		return r;
	endfunction

	mode_t                  mode_q, mode_d;
	logic [15:0]            hex_q, hex_d;
	logic [1:0]             cnt_q, cnt_d;
	logic [9:0]             pend_q, pend_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;

	logic        active, err, done, flush;
	logic        do_str, do_esc, do_hex, paired;
	logic        main_raw, main_cp;
	logic [7:0]  raw_b;
	logic [20:0] cp;
	logic [4:0]  hv;
	logic [8:0]  ev;
	logic [15:0] acc;
	enc_t        enc;
	logic [7:0]  c;

	assign c = item.text_byte;

	always_comb begin
		mode_d = mode_q;
		hex_d = hex_q;
		cnt_d = cnt_q;
		pend_d = pend_q;
		off_d = off_q;
		active = 1'b1;
		err = 1'b0;
		done = 1'b0;
		flush = 1'b0;
		do_str = 1'b0;
		do_esc = 1'b0;
		do_hex = 1'b0;
		paired = 1'b0;
		main_raw = 1'b0;
		main_cp = 1'b0;
		raw_b = '0;
		cp = '0;
		hv = hex_val(c);
		ev = esc_simple(c);
		acc = {hex_q[11:0], hv[3:0]};

		if (item.start_flag) begin
			hex_d = '0;
			cnt_d = '0;
			pend_d = '0;
			if (c != CH_QUOTE) begin
				err = 1'b1;
			end else begin
				mode_d = MODE_STR;
				off_d = OFFSET_BITS'(1);
			end
		end else if (mode_q == MODE_IDLE) begin
			active = 1'b0;
		end else begin
			if (off_q < OFF_LIMIT) begin
				off_d = off_q + 1'b1;
			end
			unique case (mode_q)
				MODE_STR: do_str = 1'b1;
				MODE_ESC: do_esc = 1'b1;
				MODE_HEX: do_hex = 1'b1;
				MODE_PEND: begin
					if (c == CH_BSL) begin
						mode_d = MODE_PEND_ESC;
					end else begin
						flush = 1'b1;
						mode_d = MODE_STR;
						do_str = 1'b1;
					end
				end
				MODE_PEND_ESC: begin
					if (c == CH_U) begin
						hex_d = '0;
						cnt_d = '0;
						mode_d = MODE_PEND_HEX;
					end else begin
						flush = 1'b1;
						do_esc = 1'b1;
					end
				end
				MODE_PEND_HEX: begin
					do_hex = 1'b1;
					paired = 1'b1;
				end
				default: err = 1'b1;
			endcase

			if (do_str) begin
				if (c == CH_QUOTE) begin
					done = 1'b1;
				end else if (c == CH_BSL) begin
					mode_d = MODE_ESC;
				end else begin
					main_raw = 1'b1;
					raw_b = c;
				end
			end

			if (do_esc) begin
				mode_d = MODE_STR;
				if (ev[8]) begin
					main_raw = 1'b1;
					raw_b = ev[7:0];
				end else if (c == CH_U) begin
					hex_d = '0;
					cnt_d = '0;
					mode_d = MODE_HEX;
				end else begin
					err = 1'b1;
				end
			end

			if (do_hex) begin
				if (!hv[4]) begin
					err = 1'b1;
				end else begin
					hex_d = acc;
					cnt_d = cnt_q + 1'b1;
					if (cnt_q == 2'd3) begin
						if (paired && acc >= 16'hDC00 && acc <= 16'hDFFF) begin
							main_cp = 1'b1;
							cp = 21'({pend_q, acc[9:0]}) + 21'h10000;
							pend_d = '0;
							mode_d = MODE_STR;
						end else begin
							flush = paired;
							if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
								pend_d = acc[9:0];
								mode_d = MODE_PEND;
							end else begin
								main_cp = 1'b1;
								cp = 21'(acc);
								pend_d = '0;
								mode_d = MODE_STR;
							end
						end
					end
				end
			end
		end

		if (active && !err && !done && item.text_end) begin
			err = 1'b1;
		end
		if (err || done) begin
			mode_d = MODE_IDLE;
			hex_d = '0;
			cnt_d = '0;
			pend_d = '0;
			off_d = '0;
		end
	end

	// Assemble the record: an unpaired high surrogate goes first, then the main bytes.
	always_comb begin
		enc = '0;
		if (main_cp) begin
			enc = utf8(cp);
		end else if (main_raw) begin
			enc.b[0] = raw_b;
			enc.n = 3'd1;
		end
		rec = '0;
		if (err) begin
			rec.has_tail = 1'b1;
			rec.tail_status = STATUS_ERROR;
		end else begin
			if (flush) begin
				rec.bytes[0] = 8'hED;
				rec.bytes[1] = {4'hA, pend_q[9:6]};
				rec.bytes[2] = {2'b10, pend_q[5:0]};
				rec.bytes[3] = enc.b[0];
				rec.bytes[4] = enc.b[1];
				rec.bytes[5] = enc.b[2];
				rec.nbytes = enc.n + 3'd3;
			end else begin
				rec.bytes[0] = enc.b[0];
				rec.bytes[1] = enc.b[1];
				rec.bytes[2] = enc.b[2];
				rec.bytes[3] = enc.b[3];
				rec.nbytes = enc.n;
			end
			if (done) begin
				rec.has_tail = 1'b1;
				rec.tail_status = STATUS_DONE;
				rec.count = 16'(off_d == '0 ? off_q + 1'b1 : off_q + 1'b1);
				if (off_q >= OFF_LIMIT) begin
					rec.count = 16'(off_q);
				end
			end
		end
	end

	assign push = accept && active && (err || rec.has_tail || rec.nbytes != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hex_q <= '0;
			cnt_q <= '0;
			pend_q <= '0;
			off_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			hex_q <= hex_d;
			cnt_q <= cnt_d;
			pend_q <= pend_d;
			off_q <= off_d;
		end
	end

endmodule

// ----- design/jsu_queue.sv -----
// Short record queue between the parser and the result serializer.
// Depends on jsu_pkg.
module jsu_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::rec_t    wr_rec,
	input  logic             pop,
	output jsu_pkg::rec_t    head,
	output jsu_pkg::q_stat_t stat
);
	import jsu_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	rec_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head = mem_q[rd_q];
	assign stat.full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign stat.nonempty = (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/jsu_back.sv -----
// Result serializer: walks the head record and loads one result per cycle into
// the output register while it is empty or being taken. Depends on jsu_pkg.
module jsu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  jsu_pkg::rec_t      head,
	input  jsu_pkg::q_stat_t   stat,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output jsu_pkg::out_item_t result_item
);
	import jsu_pkg::*;

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       is_last, load;
	logic [7:0] cur_byte;
	out_item_t  res;
	out_item_t  out_q;
	logic       valid_q;

	assign total = head.nbytes + 3'(head.has_tail);
	assign is_last = (idx_q == total - 3'd1);
	assign load = stat.nonempty && (!valid_q || result_ready);
	assign pop = load && is_last;

	always_comb begin
		case (idx_q)
			3'd0:    cur_byte = head.bytes[0];
			3'd1:    cur_byte = head.bytes[1];
			3'd2:    cur_byte = head.bytes[2];
			3'd3:    cur_byte = head.bytes[3];
			3'd4:    cur_byte = head.bytes[4];
			3'd5:    cur_byte = head.bytes[5];
			default: cur_byte = '0;
		endcase
		res = '0;
		if (idx_q < head.nbytes) begin
			res.out_byte = cur_byte;
			res.has_byte = 1'b1;
			res.status = STATUS_DECODING;
		end else begin
			res.status = head.tail_status;
			res.consumed_count = (head.tail_status == STATUS_DONE) ? head.count : '0;
		end
		res.last = is_last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign result_item = out_q;

endmodule

// ----- design/json_string_unescape_utf8_top.sv -----
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Usage:
//   text channel   (text_valid/text_ready/text_item): one JSON text byte per item.
//                  Raise start_flag on the opening quote; text_end on the last byte.
//   result channel (result_valid/result_ready/result_item): decoded UTF-8 bytes,
//                  then a done item carrying consumed_count, or one error item.
//                  last marks the final result caused by a given text byte.
// Path: an accepted item's record is written into the queue, then its first
//   result is loaded into the output register. Throughput: one text item per
//   cycle while each byte causes at most one result and result_ready is high.
//   A byte causing k results (up to six, e.g. an unpaired high surrogate and
//   another escape) holds the serializer's single output register for k loads.
// Stall: when result_ready drops, the output item holds and the two-record queue
//   fills; text_ready falls only when the queue is full.
// Reset: arst_n clears parser state to idle, empties the queue and drops
//   result_valid. After an error result, drop bytes already taken downstream.
module json_string_unescape_utf8_top #(
	parameter int OFFSET_BITS = jsu_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_ready,
	input  jsu_pkg::in_item_t  text_item,
	output logic               result_valid,
	input  logic               result_ready,
	output jsu_pkg::out_item_t result_item
);
	import jsu_pkg::*;

	logic    accept, push, pop;
	rec_t    rec, head;
	q_stat_t stat;

	// Take a byte whenever the queue has room for the record it may produce.
	assign text_ready = !stat.full;
	assign accept = text_valid && text_ready;

	jsu_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (text_item),
		.push   (push),
		.rec    (rec)
	);

	jsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (rec),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.stat         (stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for json_string_unescape_utf8_top: JSON text bytes in,
// UTF-8 result items out, checked against a cycle-free predictor kept in this file.
// Depends on jsu_pkg and the block's top level.
`timescale 1ns / 1ps

module tb_top;
	import jsu_pkg::*;

	// Escape letters and the control bytes they decode to.
	localparam logic [7:0] CH_B     = "b";
	localparam logic [7:0] CH_F     = "f";
	localparam logic [7:0] CH_N     = "n";
	localparam logic [7:0] CH_R     = "r";
	localparam logic [7:0] CH_T     = "t";
	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_FF  = 8'h0C;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] DIGIT_0  = "0";
	localparam logic [7:0] DIGIT_9  = "9";
	localparam logic [7:0] UPPER_A  = "A";
	localparam logic [7:0] UPPER_F  = "F";
	localparam logic [7:0] LOWER_A  = "a";
	localparam logic [7:0] LOWER_F  = "f";

	// Byte count stops at the smaller of the counter's range and 16 bits.
	localparam logic [15:0] OFFSET_LIMIT = (OFFSET_BITS_DEF >= 16) ? 16'hFFFF :
		16'((1 << OFFSET_BITS_DEF) - 1);

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       text_valid   = 1'b0;
	logic       text_ready;
	in_item_t   text_item    = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	out_item_t  result_item;

	json_string_unescape_utf8_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_item    (text_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Decoder state as the predictor sees it.
	mode_t       p_mode       = MODE_IDLE;
	logic [15:0] p_hex        = '0;
	logic [2:0]  p_digits     = '0;
	logic [9:0]  p_high       = '0;
	logic        p_high_valid = 1'b0;
	logic [15:0] p_offset     = '0;

	// Per-byte scratch: decoded bytes, error and end flags of the current item.
	logic [7:0]  step_bytes[$];
	bit          step_err;
	bit          step_done;

	out_item_t   expected_results[$];
	in_item_t    text_q[$];
	int          early_end_at = -1;
	int          mismatches   = 0;

	int          tx_idle_pct  = 0;
	int          rx_stall_pct = 0;
	logic        hold_toggle  = 1'b0;
	logic        hold_seen    = 1'b0;
	int          hold_left    = 0;
	int          idle_cycles  = 0;
	out_item_t   want;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function void clear_parser();
		p_mode       = MODE_IDLE;
		p_hex        = '0;
		p_digits     = '0;
		p_high       = '0;
		p_high_valid = 1'b0;
		p_offset     = '0;
	endfunction

	// Append one decoded byte of the current item.
	function void put_step_byte(logic [7:0] b);
		step_bytes = {step_bytes, b};
	endfunction

	// Append one predicted result.
	function void expect_result(out_item_t r);
		expected_results = {expected_results, r};
	endfunction

	// Encode one code point (up to 0x10FFFF) as UTF-8 into the step buffer.
	function void emit_cp(logic [20:0] cp);
		if (cp <= 21'h7F) begin
			put_step_byte(cp[7:0]);
		end else if (cp <= 21'h7FF) begin
			put_step_byte({3'b110, cp[10:6]});
			put_step_byte({2'b10, cp[5:0]});
		end else if (cp <= 21'hFFFF) begin
			put_step_byte({4'b1110, cp[15:12]});
			put_step_byte({2'b10, cp[11:6]});
			put_step_byte({2'b10, cp[5:0]});
		end else begin
			put_step_byte({5'b11110, cp[20:18]});
			put_step_byte({2'b10, cp[17:12]});
			put_step_byte({2'b10, cp[11:6]});
			put_step_byte({2'b10, cp[5:0]});
		end
	endfunction

	function automatic int hex_val(logic [7:0] c);
		if (c >= DIGIT_0 && c <= DIGIT_9)
			return int'(c - DIGIT_0);
		if (c >= LOWER_A && c <= LOWER_F)
			return int'(c - LOWER_A) + 10;
		if (c >= UPPER_A && c <= UPPER_F)
			return int'(c - UPPER_A) + 10;
		return -1;
	endfunction

	// Emit the held high surrogate on its own, as three bytes.
	function void flush_high();
		emit_cp(21'hD800 + {11'd0, p_high});
		p_high       = '0;
		p_high_valid = 1'b0;
	endfunction

	function void finish_escape(logic [15:0] cp);
		if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
			p_high       = cp[9:0];
			p_high_valid = 1'b1;
			p_mode       = MODE_PEND;
		end else begin
			emit_cp({5'd0, cp});
			p_mode = MODE_STR;
		end
	endfunction

	function void on_str(logic [7:0] c);
		if (c == CH_QUOTE)
			step_done = 1'b1;
		else if (c == CH_BSL)
			p_mode = MODE_ESC;
		else
			put_step_byte(c);
	endfunction

	function void on_esc(logic [7:0] c);
		p_mode = MODE_STR;
		case (c)
			CH_QUOTE, CH_BSL, CH_SLASH: put_step_byte(c);
			CH_B: put_step_byte(CODE_BS);
			CH_F: put_step_byte(CODE_FF);
			CH_N: put_step_byte(CODE_LF);
			CH_R: put_step_byte(CODE_CR);
			CH_T: put_step_byte(CODE_TAB);
			CH_U: begin
				p_hex    = '0;
				p_digits = '0;
				p_mode   = MODE_HEX;
			end
			default: step_err = 1'b1;
		endcase
	endfunction

	// Shift in one hex digit; true once four have been taken.
	function automatic bit take_hex(logic [7:0] c);
		int d;
		d = hex_val(c);
		if (d < 0) begin
			step_err = 1'b1;
			return 1'b0;
		end
		p_hex    = {p_hex[11:0], 4'(d)};
		p_digits = p_digits + 3'd1;
		return p_digits >= 3'd4;
	endfunction

	function void parse_byte(logic [7:0] c);
		case (p_mode)
			MODE_STR: on_str(c);
			MODE_ESC: on_esc(c);
			MODE_HEX: begin
				if (take_hex(c))
					finish_escape(p_hex);
			end
			MODE_PEND: begin
				if (c == CH_BSL) begin
					p_mode = MODE_PEND_ESC;
				end else begin
					flush_high();
					p_mode = MODE_STR;
					on_str(c);
				end
			end
			MODE_PEND_ESC: begin
				if (c == CH_U) begin
					p_hex    = '0;
					p_digits = '0;
					p_mode   = MODE_PEND_HEX;
				end else begin
					flush_high();
					on_esc(c);
				end
			end
			MODE_PEND_HEX: begin
				if (take_hex(c)) begin
					if (p_hex >= 16'hDC00 && p_hex <= 16'hDFFF) begin
						// Pair the held high half with this low half.
						emit_cp(21'h10000 + {1'b0, p_high, 10'd0} + {11'd0, p_hex[9:0]});
						p_high       = '0;
						p_high_valid = 1'b0;
						p_mode       = MODE_STR;
					end else begin
						flush_high();
						finish_escape(p_hex);
					end
				end
			end
			default: step_err = 1'b1;
		endcase
	endfunction

	// Work out every result that one accepted text item causes.
	function automatic void predict_item(in_item_t it);
		out_item_t r;
		int n;
		step_bytes.delete();
		step_err  = 1'b0;
		step_done = 1'b0;
		if (it.start_flag) begin
			clear_parser();
			if (it.text_byte != CH_QUOTE) begin
				step_err = 1'b1;
			end else begin
				p_mode   = MODE_STR;
				p_offset = 16'd1;
			end
		end else if (p_mode == MODE_IDLE) begin
			// Stray byte outside a string: nothing comes out.
			return;
		end else begin
			if (p_offset < OFFSET_LIMIT)
				p_offset = p_offset + 16'd1;
			parse_byte(it.text_byte);
		end

		// End of text anywhere but on a closing quote is an error.
		if (!step_err && !step_done && it.text_end)
			step_err = 1'b1;

		if (step_err) begin
			clear_parser();
			r = '{out_byte: 8'd0, has_byte: 1'b0, status: STATUS_ERROR,
				consumed_count: 16'd0, last: 1'b1};
			expect_result(r);
			return;
		end

		n = step_bytes.size() + (step_done ? 1 : 0);
		foreach (step_bytes[i]) begin
			r = '{out_byte: step_bytes[i], has_byte: 1'b1, status: STATUS_DECODING,
				consumed_count: 16'd0, last: (i == n - 1)};
			expect_result(r);
		end
		if (step_done) begin
			r = '{out_byte: 8'd0, has_byte: 1'b0, status: STATUS_DONE,
				consumed_count: p_offset, last: 1'b1};
			expect_result(r);
			clear_parser();
		end
	endfunction

	// ------------------------------------------------------------------
	// Text builders
	// ------------------------------------------------------------------

	// Append one item; raise text_end early if this is the chosen position.
	function void add_item(logic [7:0] b, logic s, logic e);
		in_item_t it;
		it.text_byte  = b;
		it.start_flag = s;
		it.text_end   = e || (text_q.size() == early_end_at);
		text_q = {text_q, it};
	endfunction

	function void add_byte(logic [7:0] b);
		add_item(b, 1'b0, 1'b0);
	endfunction

	// Hex digit with a random letter case.
	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 4'd10)
			return DIGIT_0 + {4'd0, v};
		return ($urandom_range(1) ? UPPER_A : LOWER_A) + {4'd0, v} - 8'd10;
	endfunction

	function void add_hex_escape(logic [15:0] cp);
		add_byte(CH_BSL);
		add_byte(CH_U);
		for (int i = 3; i >= 0; i--)
			add_byte(hex_char(cp[i*4 +: 4]));
	endfunction

	function automatic bit is_simple_esc(logic [7:0] c);
		case (c)
			CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Any byte that may stand raw inside a string.
	function automatic logic [7:0] rand_raw();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == CH_QUOTE || b == CH_BSL);
		return b;
	endfunction

	// Build one string into text_q: mostly well formed with random content,
	// now and then broken (bad escape, bad hex, early end, no opening quote,
	// no closing quote, trailing stray bytes).
	function automatic void gen_string();
		int fault;
		logic [7:0] b;
		logic [15:0] cp;
		text_q.delete();
		fault = $urandom_range(15);
		early_end_at = (fault == 12) ? $urandom_range(12, 1) : -1;
		if (fault == 13) begin
			do
				b = 8'($urandom_range(255));
			while (b == CH_QUOTE);
			add_item(b, 1'b1, 1'b0);
		end else begin
			add_item(CH_QUOTE, 1'b1, 1'b0);
		end

		repeat ($urandom_range(5)) begin
			case ($urandom_range(7))
				3: begin
					do
						b = 8'($urandom_range(255));
					while (!is_simple_esc(b));
					add_byte(CH_BSL);
					add_byte(b);
				end
				4: begin
					case ($urandom_range(5))
						0: cp = 16'($urandom_range(16'h7F));
						1: cp = 16'($urandom_range(16'h7FF, 16'h80));
						2: cp = 16'($urandom);
						3: cp = 16'hD800 + 16'($urandom_range(1023));
						4: cp = 16'hDC00 + 16'($urandom_range(1023));
						default: begin
							case ($urandom_range(3))
								0: cp = 16'h0000;
								1: cp = 16'hFFFF;
								2: cp = 16'h07FF;
								default: cp = 16'h0800;
							endcase
						end
					endcase
					add_hex_escape(cp);
				end
				5: begin
					add_hex_escape(16'hD800 + 16'($urandom_range(1023)));
					add_hex_escape(16'hDC00 + 16'($urandom_range(1023)));
				end
				// High half left alone: whatever follows decides its fate.
				6: add_hex_escape(16'hD800 + 16'($urandom_range(1023)));
				7: add_hex_escape(16'hDC00 + 16'($urandom_range(1023)));
				default: add_byte(rand_raw());
			endcase
		end

		if (fault == 10) begin
			do
				b = 8'($urandom_range(255));
			while (is_simple_esc(b) || b == CH_U);
			add_byte(CH_BSL);
			add_byte(b);
		end else if (fault == 11) begin
			if ($urandom_range(1))
				add_hex_escape(16'hD800 + 16'($urandom_range(1023)));
			add_byte(CH_BSL);
			add_byte(CH_U);
			repeat ($urandom_range(3))
				add_byte(hex_char(4'($urandom_range(15))));
			do
				b = 8'($urandom_range(255));
			while (hex_val(b) >= 0);
			add_byte(b);
		end

		// Leave the string open now and then: the next start aborts it.
		if (fault != 14)
			add_item(CH_QUOTE, 1'b0, $urandom_range(3) == 0);
		if (fault == 15)
			repeat ($urandom_range(3, 1))
				add_byte(rand_raw());
	endfunction

	// ------------------------------------------------------------------
	// Drivers, checker, watchdog
	// ------------------------------------------------------------------

	// Offer one text item, idling first at random; predict on acceptance.
	task automatic send_text(in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_item  <= it;
		text_valid <= 1'b1;
		@(posedge clk);
		while (!text_ready)
			@(posedge clk);
		predict_item(it);
	endtask

	task automatic send_queued();
		foreach (text_q[i])
			send_text(text_q[i]);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic wait_drained();
		text_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	// Result ready: random stalls, or a long hold-off when a test asks for one.
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen    <= hold_toggle;
			hold_left    <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result byte %02h has %b status %0d count %0d last %b",
					$time, result_item.out_byte, result_item.has_byte, result_item.status,
					result_item.consumed_count, result_item.last);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (result_item.out_byte !== want.out_byte ||
					result_item.has_byte !== want.has_byte ||
					result_item.status !== want.status ||
					result_item.consumed_count !== want.consumed_count ||
					result_item.last !== want.last) begin
					$display("%0t: expected byte %02h has %b status %0d count %0d last %b",
						$time, want.out_byte, want.has_byte, want.status,
						want.consumed_count, want.last);
					$display("%0t:   actual byte %02h has %b status %0d count %0d last %b",
						$time, result_item.out_byte, result_item.has_byte, result_item.status,
						result_item.consumed_count, result_item.last);
					mismatches++;
				end
			end
		end
	end

	// End the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && text_ready) || (result_valid && result_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding",
					$time, expected_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked bytes: extremes, bad start/escape, early end, restart, surrogates.
	task automatic test_directed();
		tx_idle_pct  = 0;
		rx_stall_pct <= 0;
		early_end_at = -1;
		text_q.delete();
		add_item(8'h00, 1'b1, 1'b0);        // start on a non-quote
		add_byte(8'hFF);                    // stray byte while idle
		add_item(CH_QUOTE, 1'b1, 1'b0);     // bad escape
		add_byte(CH_BSL);
		add_byte("z");
		add_item(CH_QUOTE, 1'b1, 1'b1);     // text ends on the opening quote
		add_item(CH_QUOTE, 1'b1, 1'b0);     // string cut short by a restart
		add_byte("a");
		// Raw 0xFF, the highest pair, then a high half that a plain escape follows.
		add_item(CH_QUOTE, 1'b1, 1'b0);
		add_byte(8'hFF);
		add_hex_escape(16'hDBFF);
		add_hex_escape(16'hDFFF);
		add_hex_escape(16'hD800);
		add_byte(CH_BSL);
		add_byte(CH_T);
		add_item(CH_QUOTE, 1'b0, 1'b1);
		send_queued();
		wait_drained();
	endtask

	task automatic test_random_traffic(int tx_pct, int rx_pct);
		int sent;
		tx_idle_pct  = tx_pct;
		rx_stall_pct <= rx_pct;
		sent = 0;
		while (sent < 30) begin
			gen_string();
			send_queued();
			sent += text_q.size();
		end
		wait_drained();
	endtask

	// Hold the result side off while text keeps coming, so the queue fills
	// and text_ready falls; then drain.
	task automatic test_backpressure();
		int sent;
		tx_idle_pct  = 0;
		rx_stall_pct <= 0;
		hold_toggle  <= ~hold_toggle;
		sent = 0;
		while (sent < 30) begin
			gen_string();
			send_queued();
			sent += text_q.size();
		end
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random_traffic(0, 0);
		test_random_traffic(52, 0);
		test_random_traffic(0, 52);
		test_random_traffic(13, 13);
		test_backpressure();

		// Let anything late show up before the verdict.
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
